### rtl/core/dtlv_pkg.sv
// shared types and constants for the der tlv header parser
// no dependencies; imported by dtlv_step and der_tlv_header_parser_unit
`default_nettype none

package dtlv_pkg;

  localparam int MAX_LENGTH_BYTES = 4;

  localparam logic [4:0]  TAG_HIGH_FORM  = 5'h1f;
  localparam logic [7:0]  LEN_INDEFINITE = 8'h80;
  localparam logic [7:0]  LEN_RESERVED   = 8'hff;
  localparam logic [31:0] ACC_LIMIT      = 32'h00ff_ffff;
  localparam logic [31:0] LONG_FORM_MIN  = 32'h0000_0080;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN1 = 2'd1,
    PH_LENX = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_ID      = 2'd0,
    ROLE_LEN     = 2'd1,
    ROLE_CONTENT = 2'd2,
    ROLE_IGNORED = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_HIGH_TAG   = 3'd1,
    ERR_INDEFINITE = 3'd2,
    ERR_RESERVED   = 3'd3,
    ERR_TOO_WIDE   = 3'd4,
    ERR_LEAD_ZERO  = 3'd5,
    ERR_LONG_SHORT = 3'd6,
    ERR_TRUNCATED  = 3'd7
  } err_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  held_class;
    logic        held_constructed;
    logic [4:0]  held_number;
    logic [3:0]  length_bytes_left;
    logic [31:0] length_accumulator;
    logic [31:0] content_left;
    logic [31:0] position;
    logic        failed;
    err_t        sticky_error;
  } state_t;

  typedef struct packed {
    role_t       byte_role;
    logic [31:0] byte_offset;
    logic [1:0]  id_class;
    logic        is_constructed;
    logic [4:0]  tag_number;
    logic [31:0] content_length;
    logic        header_done;
    logic        element_done;
    err_t        error_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/dtlv_step.sv
// per-byte decode: next parser state and the result word for one byte
// depends on dtlv_pkg
`default_nettype none

module dtlv_step (
  input  dtlv_pkg::state_t  state,
  input  logic [7:0]        data_byte,
  input  logic              end_of_buffer,
  output dtlv_pkg::state_t  state_next,
  output dtlv_pkg::result_t result
);
  import dtlv_pkg::*;

  logic        fail;
  err_t        code;
  logic        hdr;
  logic        eod;
  logic [31:0] clen;
  role_t       role;
  logic [31:0] acc_shifted;
  logic [3:0]  left_after;
  logic [31:0] content_after;

  always_comb begin
    state_next    = state;
    fail          = 1'b0;
    code          = ERR_OK;
    hdr           = 1'b0;
    eod           = 1'b0;
    clen          = '0;
    role          = ROLE_IGNORED;
    acc_shifted   = {state.length_accumulator[23:0], data_byte};
    left_after    = (state.length_bytes_left != 4'd0) ?
                    state.length_bytes_left - 4'd1 : state.length_bytes_left;
    content_after = (state.content_left != 32'd0) ?
                    state.content_left - 32'd1 : state.content_left;

    if (!state.failed) begin
      unique case (state.phase)
        PH_ID: begin
          role = ROLE_ID;
          state_next.held_class       = data_byte[7:6];
          state_next.held_constructed = data_byte[5];
          state_next.held_number      = data_byte[4:0];
          if (data_byte[4:0] == TAG_HIGH_FORM) begin
            fail = 1'b1;
            code = ERR_HIGH_TAG;
          end else if (end_of_buffer) begin
            fail = 1'b1;
            code = ERR_TRUNCATED;
          end else begin
            state_next.phase = PH_LEN1;
          end
        end
        PH_LEN1: begin
          role = ROLE_LEN;
          if (!data_byte[7]) begin
            if (data_byte == 8'd0) begin
              hdr = 1'b1;
              eod = 1'b1;
              state_next.phase = PH_ID;
            end else if (end_of_buffer) begin
              fail = 1'b1;
              code = ERR_TRUNCATED;
            end else begin
              hdr = 1'b1;
              clen = {24'd0, data_byte};
              state_next.content_left = {24'd0, data_byte};
              state_next.phase = PH_BODY;
            end
          end else if (data_byte == LEN_INDEFINITE) begin
            fail = 1'b1;
            code = ERR_INDEFINITE;
          end else if (data_byte == LEN_RESERVED) begin
            fail = 1'b1;
            code = ERR_RESERVED;
          end else if (data_byte[6:0] > 7'(MAX_LENGTH_BYTES)) begin
            fail = 1'b1;
            code = ERR_TOO_WIDE;
          end else if (end_of_buffer) begin
            fail = 1'b1;
            code = ERR_TRUNCATED;
          end else begin
            state_next.length_bytes_left  = data_byte[3:0];
            state_next.length_accumulator = '0;
            state_next.phase = PH_LENX;
          end
        end
        PH_LENX: begin
          role = ROLE_LEN;
          if (state.length_accumulator == 32'd0 && data_byte == 8'd0) begin
            fail = 1'b1;
            code = ERR_LEAD_ZERO;
          end else if (state.length_accumulator > ACC_LIMIT) begin
            fail = 1'b1;
            code = ERR_TOO_WIDE;
          end else begin
            state_next.length_accumulator = acc_shifted;
            state_next.length_bytes_left  = left_after;
            if (left_after == 4'd0) begin
              if (acc_shifted < LONG_FORM_MIN) begin
                fail = 1'b1;
                code = ERR_LONG_SHORT;
              end else if (end_of_buffer) begin
                fail = 1'b1;
                code = ERR_TRUNCATED;
              end else begin
                hdr = 1'b1;
                clen = acc_shifted;
                state_next.content_left = acc_shifted;
                state_next.phase = PH_BODY;
              end
            end else if (end_of_buffer) begin
              fail = 1'b1;
              code = ERR_TRUNCATED;
            end
          end
        end
        PH_BODY: begin
          role = ROLE_CONTENT;
          state_next.content_left = content_after;
          if (content_after == 32'd0) begin
            eod = 1'b1;
            state_next.phase = PH_ID;
          end else if (end_of_buffer) begin
            fail = 1'b1;
            code = ERR_TRUNCATED;
          end
        end
        default: begin
          role = ROLE_IGNORED;
        end
      endcase
      if (fail) begin
        state_next.failed       = 1'b1;
        state_next.sticky_error = code;
        hdr  = 1'b0;
        eod  = 1'b0;
        clen = '0;
      end
    end

    state_next.position = end_of_buffer ? 32'd0 : state.position + 32'd1;

    result.byte_role      = role;
    result.byte_offset    = state.position;
    result.content_length = clen;
    result.header_done    = hdr;
    result.element_done   = eod;
    result.error_code     = state_next.failed ? state_next.sticky_error : ERR_OK;
    if (role == ROLE_IGNORED) begin
      result.id_class       = '0;
      result.is_constructed = 1'b0;
      result.tag_number     = '0;
    end else begin
      result.id_class       = state_next.held_class;
      result.is_constructed = state_next.held_constructed;
      result.tag_number     = state_next.held_number;
    end
  end

endmodule

`default_nettype wire

### rtl/core/der_tlv_header_parser_unit.sv
// top level of the der tlv header parser: input register, step decode, result queue
// depends on dtlv_pkg and dtlv_step
//
// usage:
//   s_* carries the encoded buffer one byte per word; s_tlast marks the
//   buffer's final byte. m_* returns one result word per input byte, in order.
//   each byte's result passes the input register, then the decode into the
//   result queue, before it is offered on m_*.
//   throughput: one byte per cycle while the result queue has room; the header
//   state update is a single pass of small per-phase logic, so nothing iterates.
//   the result side has a two-word queue, so input keeps flowing while one
//   result waits; when the receiver stalls with the queue full, s_tready
//   drops once the input register is also occupied, and nothing is lost.
//   reset (rst, synchronous) returns the parser to the identifier phase at
//   buffer offset 0, clears any latched error and empties both stages.
//   after an encoding error every later byte is reported as ignored, with
//   the latched code, until the next reset.
`default_nettype none

module der_tlv_header_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // end_of_buffer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // byte_offset, id_class, is_constructed, tag_number,
                                 // content_length, header_done, error_code, zero pad
  output logic [1:0]  m_tuser,   // byte_role
  output logic        m_tlast    // element_done
);
  import dtlv_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  state_t      state;
  state_t      state_next;
  result_t     res;
  result_t     queue [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;
  logic        room;
  logic        advance;
  result_t     head;

  assign pop      = m_tvalid && m_tready;
  assign room     = (count != 2'd2) || pop;
  assign advance  = in_valid && room;
  assign s_tready = !in_valid || room;

  dtlv_step u_step (
    .state         (state),
    .data_byte     (in_byte),
    .end_of_buffer (in_last),
    .state_next    (state_next),
    .result        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (advance) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({advance, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (advance) begin
      queue[wr_ptr] <= res;
    end
  end

  assign head     = queue[rd_ptr];
  assign m_tvalid = (count != 2'd0);
  assign m_tuser  = head.byte_role;
  assign m_tlast  = head.element_done;
  assign m_tdata  = {4'd0, head.error_code, head.header_done, head.content_length,
                     head.tag_number, head.is_constructed, head.id_class,
                     head.byte_offset};

`ifndef ASSERT_OFF
  a_failed_sticks: assert property (@(posedge clk) disable iff (rst)
    state.failed |=> state.failed)
    else $error("latched failure cleared without reset");

  a_ignored_has_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ROLE_IGNORED |-> m_tdata[75:73] != ERR_OK)
    else $error("ignored byte without an error code");

  a_header_on_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[72] |-> m_tuser == ROLE_LEN)
    else $error("header completion on a byte that is not a length byte");

  a_failed_ignores: assert property (@(posedge clk) disable iff (rst)
    advance && state.failed |-> res.byte_role == ROLE_IGNORED)
    else $error("byte after failure not ignored");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !pop |-> !advance)
    else $error("result queue overfilled");
`endif

endmodule

`default_nettype wire
